FILE: hw/rtl/teleinfo_frame_checker_assert.svh
// assertion macros shared by the frame checker modules
`ifndef TELEINFO_FRAME_CHECKER_ASSERT_SVH
`define TELEINFO_FRAME_CHECKER_ASSERT_SVH

// property checked at every clock edge outside reset
`define TFC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define TFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tfc_pkg.sv
// shared types and constants of the frame checker
`default_nettype none

package tfc_pkg;

  localparam logic [6:0] CH_STX   = 7'h02;
  localparam logic [6:0] CH_ETX   = 7'h03;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] SUM_BIAS = 7'd32;

  localparam logic [5:0] MIN_BODY  = 6'd3;
  localparam logic [5:0] BODY_SAT  = 6'd63;
  localparam logic [5:0] LEN_RESET = 6'd40;

  localparam logic KIND_GROUP = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_STX   = 3'd1,
    CLS_ETX   = 3'd2,
    CLS_LF    = 3'd3,
    CLS_CR    = 3'd4
  } char_class_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISMATCH  = 2'd1,
    ST_MALFORMED = 2'd2
  } grp_status_t;

  typedef struct packed {
    logic [6:0]  ch;
    char_class_t cls;
  } item_t;

  // write side of the queue
  typedef struct packed {
    logic  valid;
    item_t data;
  } q_wr_t;

  // read side of the queue
  typedef struct packed {
    logic  valid;
    item_t data;
  } q_rd_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  idx;
    grp_status_t status;
    logic        frame_ok;
    logic [4:0]  count;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tfc_in_if.sv
// input character channel
`default_nettype none

interface tfc_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tfc_out_if.sv
// result channel
`default_nettype none

interface tfc_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [4:0] group_index;
  logic [1:0] group_status;
  logic       frame_ok;
  logic [4:0] group_count;

  modport source (output valid, output result_kind, output group_index,
                  output group_status, output frame_ok, output group_count,
                  input ready);
  modport sink (input valid, input result_kind, input group_index,
                input group_status, input frame_ok, input group_count,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/teleinfo_frame_checker.sv
// top level of the frame checker
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   rx_byte[6:0]
//  out_ch   out  valid/ready   result_kind, group_index, group_status, frame_ok, group_count
//  cfg_*    in   cfg_wr_en     cfg_wr_data[5:0] = max_group_length
//
// one item per cycle sustained while out_ch is not stalled; an accepted item passes
// through the front register, the queue and the result register in the back stage
// reset is synchronous on rst_n, no clearing pass, ready again the cycle after
// a stalled out_ch fills the result register, then the queue, then the front
// register, and only then drops in_ch.ready
`default_nettype none

module teleinfo_frame_checker #(
  parameter int MAX_GROUPS  = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  tfc_in_if.sink          in_ch,
  tfc_out_if.source       out_ch,
  input  wire logic       cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data
);
  import tfc_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_ready;
  logic  q_pop;

  tfc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_wr    (q_wr),
    .q_ready (q_ready)
  );

  tfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_ready (q_ready),
    .q_rd    (q_rd),
    .q_pop   (q_pop)
  );

  tfc_back #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_rd        (q_rd),
    .q_pop       (q_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tfc_front.sv
// front stage: accepts characters and classifies them
`default_nettype none

module tfc_front (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tfc_in_if.sink      in_ch,
  output tfc_pkg::q_wr_t q_wr,
  input  wire logic   q_ready
);
  import tfc_pkg::*;

  function automatic char_class_t classify(input logic [6:0] c);
    char_class_t k;
    case (c)
      CH_STX:  k = CLS_STX;
      CH_ETX:  k = CLS_ETX;
      CH_LF:   k = CLS_LF;
      CH_CR:   k = CLS_CR;
      default: k = CLS_OTHER;
    endcase
    return k;
  endfunction

  logic  valid_r, valid_nxt;
  item_t data_r;
  logic  take;

  assign in_ch.ready = !valid_r || q_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (q_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r.ch  <= in_ch.rx_byte;
      data_r.cls <= classify(in_ch.rx_byte);
    end
  end

  assign q_wr.valid = valid_r;
  assign q_wr.data  = data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/tfc_queue.sv
// short queue between the front and back stages
`default_nettype none
`include "teleinfo_frame_checker_assert.svh"

module tfc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  tfc_pkg::q_wr_t q_wr,
  output logic           q_ready,
  output tfc_pkg::q_rd_t q_rd,
  input  wire logic      q_pop
);
  import tfc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign q_ready = count_r != FULL;
  assign push    = q_wr.valid && q_ready;
  assign pop     = q_pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= q_wr.data;
    end
  end

  assign q_rd.valid = count_r != '0;
  assign q_rd.data  = mem_r[rd_ptr_r];

  `TFC_ASSERT(a_count_bound, clk, rst_n, count_r <= FULL, "queue count beyond depth")
  `TFC_ASSERT_IMP(a_empty_ptrs, clk, rst_n, count_r == '0, rd_ptr_r == wr_ptr_r,
                  "empty queue with pointers apart")
  `TFC_ASSERT_IMP(a_pop_has_data, clk, rst_n, q_pop, count_r != '0,
                  "pop from an empty queue")

endmodule

`default_nettype wire

FILE: hw/rtl/tfc_back.sv
// back stage: frame hunt, group checksum and result register
`default_nettype none
`include "teleinfo_frame_checker_assert.svh"

module tfc_back #(
  parameter int MAX_GROUPS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  tfc_pkg::q_rd_t  q_rd,
  output logic            q_pop,
  input  wire logic       cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data,
  tfc_out_if.source       out_ch
);
  import tfc_pkg::*;

  localparam int CAP_INT = (MAX_GROUPS - 1 < 31) ? MAX_GROUPS - 1 : 31;
  localparam logic [4:0] GROUP_CAP = 5'(CAP_INT);

  logic [5:0] max_len_r;
  logic       frame_active_r, frame_active_nxt;
  logic       prev_etx_r, prev_etx_nxt;
  logic       in_group_r, in_group_nxt;
  logic [6:0] c1_r, c1_nxt;
  logic [6:0] c2_r, c2_nxt;
  logic [5:0] sum_r, sum_nxt;
  logic [5:0] len_r, len_nxt;
  logic [4:0] groups_r, groups_nxt;
  logic       ferr_r, ferr_nxt;
  logic       overlong_r, overlong_nxt;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  result_t    res;
  logic       res_valid;
  logic [6:0] expect_ck;
  grp_status_t status;

  assign q_pop     = q_rd.valid && (!out_valid_r || out_ch.ready);
  assign expect_ck = {1'b0, sum_r} + SUM_BIAS;

  always_comb begin
    if ((len_r < MIN_BODY) || overlong_r) begin
      status = ST_MALFORMED;
    end else if (expect_ck != c1_r) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    frame_active_nxt = frame_active_r;
    prev_etx_nxt     = prev_etx_r;
    in_group_nxt     = in_group_r;
    c1_nxt           = c1_r;
    c2_nxt           = c2_r;
    sum_nxt          = sum_r;
    len_nxt          = len_r;
    groups_nxt       = groups_r;
    ferr_nxt         = ferr_r;
    overlong_nxt     = overlong_r;
    res_valid        = 1'b0;
    res              = '0;
    if (q_pop) begin
      prev_etx_nxt = q_rd.data.cls == CLS_ETX;
      if (!frame_active_r) begin
        // hunting for ETX then STX
        if (q_rd.data.cls == CLS_STX && prev_etx_r) begin
          frame_active_nxt = 1'b1;
          in_group_nxt     = 1'b0;
          groups_nxt       = '0;
          ferr_nxt         = 1'b0;
        end
      end else begin
        case (q_rd.data.cls)
          CLS_ETX: begin
            res_valid        = 1'b1;
            res.kind         = KIND_FRAME;
            res.frame_ok     = !ferr_r && !in_group_r;
            res.count        = groups_r;
            frame_active_nxt = 1'b0;
            in_group_nxt     = 1'b0;
          end
          CLS_LF: begin
            // an unfinished group is dropped
            if (in_group_r) begin
              ferr_nxt = 1'b1;
            end
            in_group_nxt = 1'b1;
            sum_nxt      = '0;
            len_nxt      = '0;
            c1_nxt       = '0;
            c2_nxt       = '0;
            overlong_nxt = 1'b0;
          end
          CLS_CR: begin
            if (in_group_r) begin
              res_valid    = 1'b1;
              res.kind     = KIND_GROUP;
              res.idx      = groups_r;
              res.status   = status;
              if (status != ST_OK) begin
                ferr_nxt = 1'b1;
              end
              if (groups_r < GROUP_CAP) begin
                groups_nxt = groups_r + 1'b1;
              end
              in_group_nxt = 1'b0;
            end
          end
          default: begin
            if (in_group_r) begin
              // sum lags two characters behind to skip separator and checksum
              if (len_r >= 6'd2) begin
                sum_nxt = sum_r + c2_r[5:0];
              end
              c2_nxt = c1_r;
              c1_nxt = q_rd.data.ch;
              if (len_r >= max_len_r) begin
                overlong_nxt = 1'b1;
              end
              if (len_r != BODY_SAT) begin
                len_nxt = len_r + 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r      <= LEN_RESET;
      frame_active_r <= 1'b0;
      prev_etx_r     <= 1'b0;
      in_group_r     <= 1'b0;
      c1_r           <= '0;
      c2_r           <= '0;
      sum_r          <= '0;
      len_r          <= '0;
      groups_r       <= '0;
      ferr_r         <= 1'b0;
      overlong_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      frame_active_r <= frame_active_nxt;
      prev_etx_r     <= prev_etx_nxt;
      in_group_r     <= in_group_nxt;
      c1_r           <= c1_nxt;
      c2_r           <= c2_nxt;
      sum_r          <= sum_nxt;
      len_r          <= len_nxt;
      groups_r       <= groups_nxt;
      ferr_r         <= ferr_nxt;
      overlong_r     <= overlong_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_r.kind;
  assign out_ch.group_index  = out_r.idx;
  assign out_ch.group_status = out_r.status;
  assign out_ch.frame_ok     = out_r.frame_ok;
  assign out_ch.group_count  = out_r.count;

  `TFC_ASSERT_IMP(a_hunt_no_group, clk, rst_n, !frame_active_r, !in_group_r,
                  "group open while hunting")
  `TFC_ASSERT_IMP(a_frame_fields, clk, rst_n, out_valid_r && out_r.kind == KIND_FRAME,
                  out_r.idx == '0 && out_r.status == ST_OK,
                  "frame result with group fields set")
  `TFC_ASSERT_IMP(a_group_fields, clk, rst_n, out_valid_r && out_r.kind == KIND_GROUP,
                  out_r.count == '0 && !out_r.frame_ok && out_r.status != 2'd3,
                  "group result with bad fields")
  `TFC_ASSERT(a_groups_cap, clk, rst_n, groups_r <= GROUP_CAP, "group count past cap")

endmodule

`default_nettype wire
